FILE: rtl/gamepad_command_responder_core_defines.svh
// ----------------------------------------------------------------------------
// gamepad_command_responder_core_defines
// Assertion macros shared by the responder core. The clock and reset are taken
// as i_clk and i_rst_n of the including module.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_COMMAND_RESPONDER_CORE_DEFINES_SVH
`define GAMEPAD_COMMAND_RESPONDER_CORE_DEFINES_SVH

// Same-cycle implication, masked during reset
`define GCR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset
`define GCR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/gcr_pkg.sv
// ----------------------------------------------------------------------------
// gcr_pkg
// Types and constants shared by the command responder front end, queue and
// byte sequencer.
// ----------------------------------------------------------------------------
package gcr_pkg;

    // Response geometry
    localparam int RESP_MAX = 10;
    localparam int IDX_W    = 4;

    // Command codes (first request byte)
    localparam logic [7:0] CMD_STATUS    = 8'h00;
    localparam logic [7:0] CMD_RESET     = 8'hff;
    localparam logic [7:0] CMD_READ      = 8'h40;
    localparam logic [7:0] CMD_ORIGIN    = 8'h41;
    localparam logic [7:0] CMD_RECAL     = 8'h42;
    localparam logic [7:0] CMD_LONG_READ = 8'h43;

    // Analog packing modes for read
    localparam logic [7:0] MODE_1 = 8'd1;
    localparam logic [7:0] MODE_2 = 8'd2;
    localparam logic [7:0] MODE_3 = 8'd3;
    localparam logic [7:0] MODE_4 = 8'd4;

    // Fixed response content
    localparam logic [7:0]  STATUS_ID      = 8'h09;
    localparam logic [7:0]  NIBBLE_HI      = 8'hf0;
    localparam logic [7:0]  BYTE1_FIXED    = 8'h80;
    localparam logic [14:0] TRIG_FULL_SCALE = 15'd32767;
    localparam logic [5:0]  READ_MIN_SEND  = 6'd3;
    localparam logic [5:0]  READ_LEN       = 6'd8;
    localparam logic [5:0]  LONG_LEN       = 6'd10;

    // Last byte index for each response length
    localparam logic [IDX_W-1:0] LAST_STATUS = 4'd2;
    localparam logic [IDX_W-1:0] LAST_READ   = 4'd7;
    localparam logic [IDX_W-1:0] LAST_LONG   = 4'd9;
    localparam logic [IDX_W-1:0] LAST_BAD    = 4'd0;

    // Configuration register indexes
    localparam logic [2:0] CFG_STICK_ORIGIN    = 3'd0;
    localparam logic [2:0] CFG_CSTICK_ORIGIN   = 3'd1;
    localparam logic [2:0] CFG_TRIGGER_ORIGIN  = 3'd2;
    localparam logic [2:0] CFG_TRIGGER_RANGE   = 3'd3;
    localparam logic [2:0] CFG_CLICK_THRESHOLD = 3'd4;
    localparam logic [2:0] CFG_RUMBLE_PRESENT  = 3'd5;

    typedef struct packed {
        logic [7:0] stick_origin;
        logic [7:0] cstick_origin;
        logic [7:0] trigger_origin;
        logic [7:0] trigger_range;
        logic [7:0] click_threshold;
        logic       rumble_present;
    } t_cfg;

    // One queued response
    typedef struct packed {
        logic [RESP_MAX-1:0][7:0] bytes;
        logic [IDX_W-1:0]         last_idx;
        logic                     valid_res;
        logic                     overflow;
        logic                     motor_on;
    } t_resp;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic busy;
    } t_back_stat;

endpackage

FILE: rtl/gcr_front.sv
// ----------------------------------------------------------------------------
// gcr_front
// Accepts commands, scales the controls and builds the whole response in a
// registered stage A and a combinational stage B, then writes it to the response queue. Holds the
// origin-pending and motor state.
// ----------------------------------------------------------------------------
module gcr_front
    import gcr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [111:0] i_s_tdata,
    input  t_q_stat      i_q_stat,
    output logic         o_push,
    output t_resp        o_resp
);

    typedef enum logic [2:0] {
        K_STATUS,
        K_READ,
        K_ORIGIN,
        K_LONG,
        K_BAD
    } t_kind;

    // Trigger position: floor(prod / 32767), clamped to the range
    function automatic logic [7:0] trig_pos(input logic [22:0] prod,
                                            input logic [7:0]  range);
        logic [7:0]  q;
        logic [15:0] rem;
        logic [8:0]  qc;
        q   = prod[22:15];
        rem = {1'b0, prod[14:0]} + {8'd0, q};
        qc  = {1'b0, q} + ((rem >= {1'b0, TRIG_FULL_SCALE}) ? 9'd1 : 9'd0);
        if (qc > {1'b0, range}) qc = {1'b0, range};
        return qc[7:0];
    endfunction

    // Field unpacking
    logic [7:0]  w_cmd, w_mode, w_x, w_y, w_cx, w_cy;
    logic [5:0]  w_send, w_recv;
    logic        w_rum;
    logic [15:0] w_lt, w_rt;
    logic [11:0] w_btn;

    assign w_cmd  = i_s_tdata[7:0];
    assign w_send = i_s_tdata[13:8];
    assign w_recv = i_s_tdata[19:14];
    assign w_mode = i_s_tdata[27:20];
    assign w_rum  = i_s_tdata[28];
    assign w_x    = i_s_tdata[36:29];
    assign w_y    = i_s_tdata[44:37];
    assign w_cx   = i_s_tdata[52:45];
    assign w_cy   = i_s_tdata[60:53];
    assign w_lt   = i_s_tdata[76:61];
    assign w_rt   = i_s_tdata[92:77];
    assign w_btn  = i_s_tdata[104:93];

    // Stage A registers
    logic        r_a_valid;
    logic [7:0]  r_cmd, r_mode, r_sx, r_sy, r_cx, r_cy;
    logic [5:0]  r_send, r_recv;
    logic        r_rum;
    logic [22:0] r_prod_l, r_prod_r;
    logic [11:0] r_btn;

    // Persistent state
    logic r_origin_pending, n_origin_pending;
    logic r_motor_running, n_motor_running;

    logic w_load;

    assign o_push     = r_a_valid && !i_q_stat.full;
    assign o_s_tready = !r_a_valid || !i_q_stat.full;
    assign w_load     = i_s_tvalid && o_s_tready;

    // Stage A: axis offsets and trigger products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_load) begin
            r_a_valid <= 1'b1;
        end else if (o_push) begin
            r_a_valid <= 1'b0;
        end
        if (w_load) begin
            r_cmd  <= w_cmd;
            r_mode <= w_mode;
            r_send <= w_send;
            r_recv <= w_recv;
            r_rum  <= w_rum;
            r_btn  <= w_btn;
            r_sx   <= i_cfg.stick_origin + w_x;
            r_sy   <= i_cfg.stick_origin - w_y;
            r_cx   <= i_cfg.cstick_origin + w_cx;
            r_cy   <= i_cfg.cstick_origin - w_cy;
            // only a positive raw axis moves the trigger
            r_prod_l <= (!w_lt[15] && w_lt != 16'd0) ?
                        {8'd0, w_lt[14:0]} * {15'd0, i_cfg.trigger_range} : 23'd0;
            r_prod_r <= (!w_rt[15] && w_rt != 16'd0) ?
                        {8'd0, w_rt[14:0]} * {15'd0, i_cfg.trigger_range} : 23'd0;
        end
    end

    // Stage B: trigger readings and buttons
    logic [7:0] w_al0, w_ar0, w_al, w_ar, w_full, w_b0, w_b1;
    logic       w_bl, w_br, w_up, w_dn, w_lf, w_rgt;

    always_comb begin
        w_full = i_cfg.trigger_origin + i_cfg.trigger_range;
        w_al0  = i_cfg.trigger_origin + trig_pos(r_prod_l, i_cfg.trigger_range);
        w_ar0  = i_cfg.trigger_origin + trig_pos(r_prod_r, i_cfg.trigger_range);
        w_bl   = r_btn[6] || (w_al0 >= i_cfg.click_threshold);
        w_br   = r_btn[7] || (w_ar0 >= i_cfg.click_threshold);
        w_al   = w_bl ? w_full : w_al0;
        w_ar   = w_br ? w_full : w_ar0;
        w_up   = r_btn[8];
        w_dn   = r_btn[9];
        w_lf   = r_btn[10];
        w_rgt  = r_btn[11];
        w_b0   = {2'b00, r_origin_pending, r_btn[5], r_btn[3], r_btn[2], r_btn[1], r_btn[0]};
        w_b1   = BYTE1_FIXED | {1'b0, w_bl, w_br, r_btn[4], w_up & ~w_dn, w_dn & ~w_up,
                                w_rgt & ~w_lf, w_lf & ~w_rgt};
    end

    // Stage B: classify the command
    t_kind w_kind;

    always_comb begin
        priority if (r_cmd == CMD_STATUS || r_cmd == CMD_RESET) begin
            w_kind = K_STATUS;
        end else if (r_cmd == CMD_READ && r_send >= READ_MIN_SEND) begin
            w_kind = K_READ;
        end else if (r_cmd == CMD_ORIGIN || r_cmd == CMD_RECAL) begin
            w_kind = K_ORIGIN;
        end else if (r_cmd == CMD_LONG_READ) begin
            w_kind = K_LONG;
        end else begin
            w_kind = K_BAD;
        end
    end

    // Stage B: response bytes and state update
    logic [7:0] w_c_pack, w_t_pack;

    always_comb begin
        w_c_pack         = (r_cx & NIBBLE_HI) | {4'd0, r_cy[7:4]};
        w_t_pack         = (w_al & NIBBLE_HI) | {4'd0, w_ar[7:4]};
        n_origin_pending = r_origin_pending;
        n_motor_running  = r_motor_running;
        o_resp           = '0;
        o_resp.valid_res = 1'b1;
        unique case (w_kind)
            K_STATUS: begin
                o_resp.bytes[0] = STATUS_ID;
                o_resp.bytes[2] = {4'd0, i_cfg.rumble_present & r_motor_running, 3'd0};
                o_resp.last_idx = LAST_STATUS;
            end
            K_READ: begin
                if (i_cfg.rumble_present) n_motor_running = r_rum;
                o_resp.bytes[0] = w_b0;
                o_resp.bytes[1] = w_b1;
                o_resp.bytes[2] = r_sx;
                o_resp.bytes[3] = r_sy;
                unique case (r_mode)
                    MODE_1: begin
                        o_resp.bytes[4] = w_c_pack;
                        o_resp.bytes[5] = w_al;
                        o_resp.bytes[6] = w_ar;
                    end
                    MODE_2: begin
                        o_resp.bytes[4] = w_c_pack;
                        o_resp.bytes[5] = w_t_pack;
                    end
                    MODE_3: begin
                        o_resp.bytes[4] = r_cx;
                        o_resp.bytes[5] = r_cy;
                        o_resp.bytes[6] = w_al;
                        o_resp.bytes[7] = w_ar;
                    end
                    MODE_4: begin
                        o_resp.bytes[4] = r_cx;
                        o_resp.bytes[5] = r_cy;
                    end
                    default: begin
                        o_resp.bytes[4] = r_cx;
                        o_resp.bytes[5] = r_cy;
                        o_resp.bytes[6] = w_t_pack;
                    end
                endcase
                o_resp.last_idx = LAST_READ;
                o_resp.overflow = r_recv > READ_LEN;
            end
            K_ORIGIN: begin
                n_origin_pending = 1'b0;
                o_resp.bytes[1]  = BYTE1_FIXED;
                o_resp.bytes[2]  = i_cfg.stick_origin;
                o_resp.bytes[3]  = i_cfg.stick_origin;
                o_resp.bytes[4]  = i_cfg.cstick_origin;
                o_resp.bytes[5]  = i_cfg.cstick_origin;
                o_resp.bytes[6]  = i_cfg.trigger_origin;
                o_resp.bytes[7]  = i_cfg.trigger_origin;
                o_resp.last_idx  = LAST_LONG;
                o_resp.overflow  = r_recv > LONG_LEN;
            end
            K_LONG: begin
                o_resp.bytes[0] = w_b0;
                o_resp.bytes[1] = w_b1;
                o_resp.bytes[2] = r_sx;
                o_resp.bytes[3] = r_sy;
                o_resp.bytes[4] = r_cx;
                o_resp.bytes[5] = r_cy;
                o_resp.bytes[6] = w_al;
                o_resp.bytes[7] = w_ar;
                o_resp.last_idx = LAST_LONG;
                o_resp.overflow = r_recv > LONG_LEN;
            end
            default: begin
                o_resp.valid_res = 1'b0;
                o_resp.last_idx  = LAST_BAD;
            end
        endcase
        // motor drive as seen after this command
        o_resp.motor_on = i_cfg.rumble_present & n_motor_running;
    end

    // State commits when the response enters the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_pending <= 1'b1;
            r_motor_running  <= 1'b0;
        end else if (o_push) begin
            r_origin_pending <= n_origin_pending;
            r_motor_running  <= n_motor_running;
        end
    end

endmodule

FILE: rtl/gcr_queue.sv
// ----------------------------------------------------------------------------
// gcr_queue
// Small first-in first-out queue of complete responses between the front end
// and the byte sequencer.
// ----------------------------------------------------------------------------
module gcr_queue
    import gcr_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_resp   i_resp,
    input  logic    i_pop,
    output t_resp   o_resp,
    output t_q_stat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_resp              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_stat.full  = r_count == CNT_W'(DEPTH);
    assign o_stat.empty = r_count == '0;
    assign o_resp       = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_resp;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/gcr_back.sv
// ----------------------------------------------------------------------------
// gcr_back
// Byte sequencer: takes one response from the queue and sends its bytes one
// per cycle, while the receiver is ready, through an output register.
// ----------------------------------------------------------------------------
module gcr_back
    import gcr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_resp       i_resp,
    input  t_q_stat     i_q_stat,
    output logic        o_pop,
    output t_back_stat  o_stat,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,
    output logic        o_m_tlast,
    output logic [2:0]  o_m_tuser
);

    logic             r_busy;
    t_resp            r_cur;
    logic [IDX_W-1:0] r_idx;

    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_idx;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic [2:0]       r_out_user;

    logic w_out_ready, w_emit, w_cur_last;

    assign w_out_ready = !r_out_valid || i_m_tready;
    assign w_emit      = r_busy && w_out_ready;
    assign w_cur_last  = r_idx == r_cur.last_idx;
    assign o_pop       = !i_q_stat.empty && (!r_busy || (w_emit && w_cur_last));
    assign o_stat.busy = r_busy;

    // Current response and byte pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
        end else if (w_emit && w_cur_last) begin
            r_busy <= 1'b0;
        end
        if (o_pop) begin
            r_cur <= i_resp;
            r_idx <= '0;
        end else if (w_emit && !w_cur_last) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_emit) begin
            r_out_idx  <= r_idx;
            r_out_byte <= r_cur.bytes[r_idx];
            r_out_last <= w_cur_last;
            r_out_user <= {r_cur.motor_on, r_cur.overflow, r_cur.valid_res};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out_byte, r_out_idx};
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_user;

endmodule

FILE: rtl/gamepad_command_responder_core.sv
// ----------------------------------------------------------------------------
// gamepad_command_responder_core
// Controller-side responder: answers each host command with a run of
// response bytes built from the sampled controls and the origin settings.
// ----------------------------------------------------------------------------
// A command is taken on every cycle while the response queue has room; its
// response is built in the stage A registers and stage B logic and queued
// whole. The byte sequencer then sends one byte per cycle while the receiver
// is ready; a response holds 3 (status), 8 (read), 10 (origin, recalibrate,
// long read) or 1 (unrecognised) bytes, and the output rate, not the front
// end, sets the sustained throughput. The user must write the configuration
// only while the block is idle; the block itself does not enforce this.
module gamepad_command_responder_core
    import gcr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration write port
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [7:0]   i_cfg_wdata,
    // command request
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // from bit 0: command[8], send_count[6], recv_count[6], mode_select[8],
    // rumble_request[1], stick_x[8], stick_y[8], cstick_x[8], cstick_y[8],
    // left_trigger_raw[16], right_trigger_raw[16], host_buttons[12], zero pad
    input  logic [111:0] i_s_tdata,
    // response bytes
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // from bit 0: byte_index[4], data_byte[8], zero pad
    output logic [15:0]  o_m_tdata,
    output logic         o_m_tlast,
    // from bit 0: valid_res, overflow, motor_on
    output logic [2:0]   o_m_tuser
);

`include "gamepad_command_responder_core_defines.svh"

    t_cfg       r_cfg;
    t_resp      w_push_resp, w_pop_resp;
    t_q_stat    w_q_stat;
    t_back_stat w_back_stat;
    logic       w_push, w_pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stick_origin    <= 8'd128;
            r_cfg.cstick_origin   <= 8'd128;
            r_cfg.trigger_origin  <= 8'd0;
            r_cfg.trigger_range   <= 8'd255;
            r_cfg.click_threshold <= 8'd242;
            r_cfg.rumble_present  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_STICK_ORIGIN:    r_cfg.stick_origin    <= i_cfg_wdata;
                CFG_CSTICK_ORIGIN:   r_cfg.cstick_origin   <= i_cfg_wdata;
                CFG_TRIGGER_ORIGIN:  r_cfg.trigger_origin  <= i_cfg_wdata;
                CFG_TRIGGER_RANGE:   r_cfg.trigger_range   <= i_cfg_wdata;
                CFG_CLICK_THRESHOLD: r_cfg.click_threshold <= i_cfg_wdata;
                CFG_RUMBLE_PRESENT:  r_cfg.rumble_present  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    gcr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_q_stat   (w_q_stat),
        .o_push     (w_push),
        .o_resp     (w_push_resp)
    );

    gcr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_resp  (w_push_resp),
        .i_pop   (w_pop),
        .o_resp  (w_pop_resp),
        .o_stat  (w_q_stat)
    );

    gcr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_resp     (w_pop_resp),
        .i_q_stat   (w_q_stat),
        .o_pop      (w_pop),
        .o_stat     (w_back_stat),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    // Checks
    `GCR_ASSERT_IMP(a_push_not_full, w_push, !w_q_stat.full, "push into full queue")
    `GCR_ASSERT_IMP(a_last_index, o_m_tvalid && o_m_tlast && o_m_tuser[0], o_m_tdata[3:0] == LAST_STATUS || o_m_tdata[3:0] == LAST_READ || o_m_tdata[3:0] == LAST_LONG, "bad final byte index")
    `GCR_ASSERT_IMP(a_over_valid, o_m_tvalid && o_m_tuser[1], o_m_tuser[0], "overflow on invalid command")
    `GCR_ASSERT_IMP(a_run_continues, o_m_tvalid && !o_m_tlast, w_back_stat.busy, "run ended early")

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb - command responder core testbench
// Drives host commands over the request stream and checks every response byte
// against a cycle-free predictor of the responder, across several origin,
// trigger and rumble settings and under random and prolonged back-pressure.
// ----------------------------------------------------------------------------
module tb;
    import gcr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES  = 200;
    localparam int QUIET_CYCLES = 8;
    localparam int BLOCK_ITEMS  = 100;

    // One host command, first field in the lowest bits as on i_s_tdata
    typedef struct packed {
        logic [11:0]        host_buttons;
        logic signed [15:0] right_trigger_raw;
        logic signed [15:0] left_trigger_raw;
        logic signed [7:0]  cstick_y;
        logic signed [7:0]  cstick_x;
        logic signed [7:0]  stick_y;
        logic signed [7:0]  stick_x;
        logic               rumble_request;
        logic [7:0]         mode_select;
        logic [5:0]         recv_count;
        logic [5:0]         send_count;
        logic [7:0]         command;
    } t_command;

    // One response byte with its side-band flags
    typedef struct packed {
        logic [3:0] byte_index;
        logic [7:0] data_byte;
        logic       last;
        logic       valid_res;
        logic       overflow;
        logic       motor_on;
    } t_out_byte;

    logic         i_clk       = 1'b0;
    logic         i_rst_n     = 1'b0;
    logic         i_cfg_we    = 1'b0;
    logic [2:0]   i_cfg_addr  = '0;
    logic [7:0]   i_cfg_wdata = '0;
    logic         i_s_tvalid  = 1'b0;
    logic         o_s_tready;
    logic [111:0] i_s_tdata   = '0;
    logic         o_m_tvalid;
    logic         i_m_tready  = 1'b0;
    logic [15:0]  o_m_tdata;
    logic         o_m_tlast;
    logic [2:0]   o_m_tuser;

    // Stimulus and expectation stores
    t_command  cmd_pending[$];
    t_out_byte resp_expected[$];
    t_command  cmd_on_bus;

    // Predictor copy of the registers and state
    t_cfg pred_cfg;
    logic pred_origin_pending;
    logic pred_motor_running;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_reqs     = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    int n_errors  = 0;
    int n_checked = 0;
    int n_status  = 0;
    int n_reads   = 0;
    int n_origin  = 0;
    int n_long    = 0;
    int n_unknown = 0;

    gamepad_command_responder_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Trigger axis to reading: positive travel scaled onto the range, clamped
    function automatic logic [7:0] trigger_reading(logic [15:0] raw);
        int unsigned pos;
        pos = 0;
        if (raw != 16'd0 && !raw[15]) begin
            pos = (int'(raw) * int'(pred_cfg.trigger_range)) / int'(TRIG_FULL_SCALE);
            if (pos > pred_cfg.trigger_range) pos = pred_cfg.trigger_range;
        end
        return pred_cfg.trigger_origin + pos[7:0];
    endfunction

    // Work out the response bytes of one accepted command and queue them
    task automatic predict_response(t_command c);
        logic [7:0] resp [RESP_MAX];
        logic [7:0] sx, sy, cx, cy, al, ar, full, b0, b1;
        logic       bl, br, up, dn, lf, rt, over, valid;
        int         n;
        t_out_byte  ob;

        sx   = pred_cfg.stick_origin + c.stick_x;
        sy   = pred_cfg.stick_origin - c.stick_y;
        cx   = pred_cfg.cstick_origin + c.cstick_x;
        cy   = pred_cfg.cstick_origin - c.cstick_y;
        al   = trigger_reading(c.left_trigger_raw);
        ar   = trigger_reading(c.right_trigger_raw);
        full = pred_cfg.trigger_origin + pred_cfg.trigger_range;
        bl   = c.host_buttons[6] || (al >= pred_cfg.click_threshold);
        br   = c.host_buttons[7] || (ar >= pred_cfg.click_threshold);
        up   = c.host_buttons[8];
        dn   = c.host_buttons[9];
        lf   = c.host_buttons[10];
        rt   = c.host_buttons[11];
        if (bl) al = full;
        if (br) ar = full;
        b0 = {2'b00, pred_origin_pending, c.host_buttons[5], c.host_buttons[3],
              c.host_buttons[2], c.host_buttons[1], c.host_buttons[0]};
        // opposite d-pad directions cancel
        b1 = BYTE1_FIXED | {1'b0, bl, br, c.host_buttons[4],
                            up & !dn, dn & !up, rt & !lf, lf & !rt};

        foreach (resp[k]) resp[k] = 8'h00;
        over  = 1'b0;
        valid = 1'b1;
        n     = 1;

        if (c.command == CMD_STATUS || c.command == CMD_RESET) begin
            // status never flags overflow
            resp[0] = STATUS_ID;
            resp[2] = {4'b0000, pred_cfg.rumble_present & pred_motor_running, 3'b000};
            n = 3;
            n_status++;
        end else if (c.command == CMD_READ && c.send_count >= READ_MIN_SEND) begin
            if (pred_cfg.rumble_present) pred_motor_running = c.rumble_request;
            resp[0] = b0;
            resp[1] = b1;
            resp[2] = sx;
            resp[3] = sy;
            case (c.mode_select)
                MODE_1: begin
                    resp[4] = (cx & NIBBLE_HI) | (cy >> 4);
                    resp[5] = al;
                    resp[6] = ar;
                end
                MODE_2: begin
                    resp[4] = (cx & NIBBLE_HI) | (cy >> 4);
                    resp[5] = (al & NIBBLE_HI) | (ar >> 4);
                end
                MODE_3: begin
                    resp[4] = cx;
                    resp[5] = cy;
                    resp[6] = al;
                    resp[7] = ar;
                end
                MODE_4: begin
                    resp[4] = cx;
                    resp[5] = cy;
                end
                default: begin
                    resp[4] = cx;
                    resp[5] = cy;
                    resp[6] = (al & NIBBLE_HI) | (ar >> 4);
                end
            endcase
            n    = 8;
            over = c.recv_count > READ_LEN;
            n_reads++;
        end else if (c.command == CMD_ORIGIN || c.command == CMD_RECAL) begin
            resp[1] = BYTE1_FIXED;
            resp[2] = pred_cfg.stick_origin;
            resp[3] = pred_cfg.stick_origin;
            resp[4] = pred_cfg.cstick_origin;
            resp[5] = pred_cfg.cstick_origin;
            resp[6] = pred_cfg.trigger_origin;
            resp[7] = pred_cfg.trigger_origin;
            pred_origin_pending = 1'b0;
            n    = 10;
            over = c.recv_count > LONG_LEN;
            n_origin++;
        end else if (c.command == CMD_LONG_READ) begin
            resp[0] = b0;
            resp[1] = b1;
            resp[2] = sx;
            resp[3] = sy;
            resp[4] = cx;
            resp[5] = cy;
            resp[6] = al;
            resp[7] = ar;
            n    = 10;
            over = c.recv_count > LONG_LEN;
            n_long++;
        end else begin
            // unrecognised, including a read with too few request bytes
            valid = 1'b0;
            n_unknown++;
        end

        for (int k = 0; k < n; k++) begin
            ob.byte_index = k[3:0];
            ob.data_byte  = resp[k];
            ob.last       = (k == n - 1);
            ob.valid_res  = valid;
            ob.overflow   = over;
            ob.motor_on   = pred_cfg.rumble_present & pred_motor_running;
            resp_expected.push_back(ob);
        end
    endtask

    // Random command, weighted towards recognised ones
    function automatic t_command random_command();
        logic [127:0] r;
        t_command     c;
        int           pick;
        r    = {$urandom, $urandom, $urandom, $urandom};
        c    = r[104:0];
        pick = $urandom_range(99);
        if (pick < 12) begin
            c.command = $urandom_range(1) ? CMD_STATUS : CMD_RESET;
        end else if (pick < 50) begin
            c.command = CMD_READ;
            if ($urandom_range(9) != 0) c.send_count = 6'($urandom_range(63, 3));
            else c.send_count = 6'($urandom_range(2));
            if ($urandom_range(4) != 0) c.mode_select = 8'($urandom_range(5));
        end else if (pick < 60) begin
            c.command = $urandom_range(1) ? CMD_ORIGIN : CMD_RECAL;
        end else if (pick < 80) begin
            c.command = CMD_LONG_READ;
        end
        // lengths around the response sizes
        if ($urandom_range(1)) c.recv_count = 6'($urandom_range(12, 7));
        // triggers: mostly positive travel, some end points
        case ($urandom_range(5))
            0: c.left_trigger_raw = 16'sh7fff;
            1: c.left_trigger_raw = 16'($urandom_range(2));
            2, 3: c.left_trigger_raw = 16'($urandom_range(32767));
            default: ;
        endcase
        case ($urandom_range(5))
            0: c.right_trigger_raw = 16'sh8000;
            1: c.right_trigger_raw = 16'sh7fff;
            2, 3: c.right_trigger_raw = 16'($urandom_range(32767));
            default: ;
        endcase
        return c;
    endfunction

    // Request driver: holds each request until accepted, gaps at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) predict_response(cmd_on_bus);
            if (!i_s_tvalid || o_s_tready) begin
                if (cmd_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cmd_on_bus = cmd_pending.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {7'b0, cmd_on_bus};
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Response receiver: random stalls plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Response checker
    always @(posedge i_clk) begin : check_responses
        t_out_byte got;
        t_out_byte want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.byte_index = o_m_tdata[3:0];
            got.data_byte  = o_m_tdata[11:4];
            got.last       = o_m_tlast;
            got.valid_res  = o_m_tuser[0];
            got.overflow   = o_m_tuser[1];
            got.motor_on   = o_m_tuser[2];
            if (resp_expected.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("%t: unexpected response byte idx %0d data %02h", $realtime,
                             got.byte_index, got.data_byte);
            end else begin
                want = resp_expected.pop_front();
                n_checked++;
                if (got !== want) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display({"%t: mismatch idx/data/last/valid/ovf/motor ",
                                  "exp %0d/%02h/%b/%b/%b/%b got %0d/%02h/%b/%b/%b/%b"},
                                 $realtime, want.byte_index, want.data_byte, want.last,
                                 want.valid_res, want.overflow, want.motor_on,
                                 got.byte_index, got.data_byte, got.last,
                                 got.valid_res, got.overflow, got.motor_on);
                end
            end
        end
    end

    // Wait until every request is taken and every response byte is back
    task automatic wait_for_quiet();
        do @(negedge i_clk);
        while (cmd_pending.size() != 0 || i_s_tvalid || resp_expected.size() != 0);
        repeat (QUIET_CYCLES) @(negedge i_clk);
    endtask

    // Write all six registers, block idle
    task automatic load_settings(t_cfg s);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_STICK_ORIGIN;
        i_cfg_wdata <= s.stick_origin;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_CSTICK_ORIGIN;
        i_cfg_wdata <= s.cstick_origin;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_TRIGGER_ORIGIN;
        i_cfg_wdata <= s.trigger_origin;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_TRIGGER_RANGE;
        i_cfg_wdata <= s.trigger_range;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_CLICK_THRESHOLD;
        i_cfg_wdata <= s.click_threshold;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_RUMBLE_PRESENT;
        i_cfg_wdata <= {7'b0, s.rumble_present};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        pred_cfg = s;
        @(negedge i_clk);
    endtask

    // Main sequence
    initial begin
        t_command c;
        t_cfg     s;

        pred_cfg = t_cfg'{stick_origin: 8'd128, cstick_origin: 8'd128,
                          trigger_origin: 8'd0, trigger_range: 8'd255,
                          click_threshold: 8'd242, rumble_present: 1'b1};
        pred_origin_pending = 1'b1;
        pred_motor_running  = 1'b0;
        cmd_on_bus = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed commands at reset settings
        send_idle_pct = 20;
        recv_idle_pct = 81;

        c = '0;
        c.send_count = 6'd3;
        c.recv_count = 6'd63;
        c.command = CMD_STATUS;
        cmd_pending.push_back(c);
        // read before origin, stick and trigger extremes, motor on
        c.recv_count = 6'd8;
        c.command = CMD_READ;
        c.rumble_request = 1'b1;
        c.stick_x = 8'sd127;
        c.stick_y = -8'sd128;
        c.cstick_x = -8'sd128;
        c.cstick_y = 8'sd127;
        c.left_trigger_raw = 16'sh7fff;
        cmd_pending.push_back(c);
        c.command = CMD_RESET;
        cmd_pending.push_back(c);
        // read with too few request bytes
        c.command = CMD_READ;
        c.send_count = 6'd2;
        cmd_pending.push_back(c);
        // every button, both d-pad pairs opposed
        c.send_count = 6'd3;
        c.mode_select = MODE_1;
        c.recv_count = 6'd9;
        c.left_trigger_raw = 16'sd1;
        c.right_trigger_raw = 16'sh8000;
        c.host_buttons = 12'hfff;
        cmd_pending.push_back(c);
        // trigger just below and at the click point, motor off
        c.mode_select = MODE_2;
        c.rumble_request = 1'b0;
        c.recv_count = 6'd8;
        c.left_trigger_raw = 16'sd30000;
        c.right_trigger_raw = 16'sd31200;
        c.host_buttons = 12'h500;
        cmd_pending.push_back(c);
        c.mode_select = MODE_3;
        c.left_trigger_raw = 16'sd0;
        c.right_trigger_raw = -16'sd1;
        c.host_buttons = 12'ha40;
        cmd_pending.push_back(c);
        c.mode_select = MODE_4;
        c.host_buttons = 12'h0b5;
        cmd_pending.push_back(c);
        c.mode_select = 8'd5;
        cmd_pending.push_back(c);
        c.mode_select = 8'd255;
        c.rumble_request = 1'b1;
        cmd_pending.push_back(c);
        c.command = CMD_ORIGIN;
        c.recv_count = 6'd11;
        cmd_pending.push_back(c);
        // origin no longer pending
        c.command = CMD_READ;
        c.mode_select = 8'd0;
        c.recv_count = 6'd0;
        cmd_pending.push_back(c);
        c.command = CMD_RECAL;
        c.recv_count = 6'd10;
        cmd_pending.push_back(c);
        c.command = CMD_LONG_READ;
        c.recv_count = 6'd11;
        c.host_buttons = 12'h08a;
        c.right_trigger_raw = 16'sh7fff;
        cmd_pending.push_back(c);
        c.recv_count = 6'd0;
        cmd_pending.push_back(c);
        c.command = 8'h44;
        cmd_pending.push_back(c);
        c.command = 8'h3f;
        cmd_pending.push_back(c);
        c.command = 8'hfe;
        cmd_pending.push_back(c);
        c.command = CMD_READ;
        c.send_count = 6'd63;
        c.recv_count = 6'd63;
        cmd_pending.push_back(c);
        c.command = CMD_STATUS;
        cmd_pending.push_back(c);
        wait_for_quiet();

        // Random blocks, one register setting each
        for (int blk = 0; blk < 4; blk++) begin
            case (blk)
                0: s = t_cfg'{stick_origin: 8'd0, cstick_origin: 8'd255,
                              trigger_origin: 8'd200, trigger_range: 8'd255,
                              click_threshold: 8'd255, rumble_present: 1'b1};
                1: s = t_cfg'{stick_origin: 8'd255, cstick_origin: 8'd0,
                              trigger_origin: 8'd0, trigger_range: 8'd0,
                              click_threshold: 8'd0, rumble_present: 1'b0};
                default: begin
                    s.stick_origin    = 8'($urandom);
                    s.cstick_origin   = 8'($urandom);
                    s.trigger_origin  = 8'($urandom);
                    s.trigger_range   = 8'($urandom);
                    s.click_threshold = 8'($urandom);
                    s.rumble_present  = (blk == 2) ? 1'b1 : 1'(($urandom));
                end
            endcase
            load_settings(s);

            case (blk)
                0: begin send_idle_pct = 20; recv_idle_pct = 81; end
                1, 2: begin send_idle_pct = 81; recv_idle_pct = 20; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase

            for (int i = 0; i < BLOCK_ITEMS; i++) cmd_pending.push_back(random_command());
            // long output stall while requests keep coming
            if (blk == 3) hold_reqs++;
            wait_for_quiet();
        end

        repeat (QUIET_CYCLES) @(negedge i_clk);
        $display("Covered %0d status, %0d read, %0d origin/recalibrate, %0d long read and",
                 n_status, n_reads, n_origin, n_long);
        $display("%0d unrecognised commands over five register settings; %0d bytes checked",
                 n_unknown, n_checked);
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("Timed out with %0d response bytes outstanding", resp_expected.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
